// ----- rtl/core/ldf_pkg.sv -----
// shared types, constants and codes of the length prefix deframer
package ldf_pkg;

   // number of channels and index width
   localparam int CHANNELS    = 16;
   localparam int CHAN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // closes reported by one tick at most
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // length prefix
   localparam int                  LEN_BYTES = 4;
   localparam int                  HCNT_W    = 2;
   localparam logic [HCNT_W-1:0]   HDR_LAST  = HCNT_W'(LEN_BYTES - 1);

   // register reset values
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd10000;
   localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd5;
   localparam logic [7:0]  IDLE_SAT         = 8'hFF;

   // result event codes
   localparam logic [2:0] EV_BYTE    = 3'd0;
   localparam logic [2:0] EV_EMPTY   = 3'd1;
   localparam logic [2:0] EV_IDLE    = 3'd2;
   localparam logic [2:0] EV_TOOLONG = 3'd3;
   localparam logic [2:0] EV_PEER    = 3'd4;

   // item function codes
   typedef enum logic [1:0] {
      OP_DATA = 2'd0,
      OP_TICK = 2'd1,
      OP_OPEN = 2'd2,
      OP_PEER = 2'd3
   } op_type;

   // register indexes
   typedef enum logic {
      CSR_MAX_LENGTH = 1'b0,
      CSR_IDLE_LIMIT = 1'b1
   } csr_index_type;

   // input transaction
   typedef struct packed {
      logic [1:0] func;
      logic [3:0] channel;
      logic [7:0] data_byte;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [3:0] out_channel;
      logic [7:0] payload;
      logic       last;
      logic [2:0] event_res;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [15:0] max_length;
      logic [7:0]  idle_limit;
   } cfg_type;

   // classified command in the queue
   typedef struct packed {
      op_type            op;
      logic [CHAN_W-1:0] chan;
      logic [7:0]        data;
   } cmd_type;

   // queue status toward the front and back
   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // per-channel state
   typedef struct packed {
      logic              open;
      logic              hdr;
      logic [HCNT_W-1:0] hcnt;
      logic [31:0]       len;
      logic [15:0]       cnt;
      logic [7:0]        idle;
   } chan_state_type;

   localparam chan_state_type CHAN_RESET = '{
      open: 1'b0, hdr: 1'b1, hcnt: '0, len: '0, cnt: '0, idle: '0
   };

endpackage

// ----- rtl/core/ldf_front.sv -----
// front end: accepts items, drops out-of-range channels, queues commands
module ldf_front (
   input  ldf_pkg::req_type    req_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  ldf_pkg::q_stat_type q_stat,
   output logic                push,
   output ldf_pkg::cmd_type    push_cmd
);
   import ldf_pkg::*;

   logic is_tick;
   logic in_range;

   // classify the transaction
   assign is_tick  = (op_type'(req_data.func) == OP_TICK);
   assign in_range = (32'(req_data.channel) < CHANNELS);

   // hold off while the queue is full
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full && (is_tick || in_range);

   // command for the back end
   assign push_cmd.op   = op_type'(req_data.func);
   assign push_cmd.chan = CHAN_W'(req_data.channel);
   assign push_cmd.data = req_data.data_byte;

endmodule

// ----- rtl/core/ldf_queue.sv -----
// short command queue between front and back end
module ldf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ldf_pkg::cmd_type    push_cmd,
   input  logic                pop,
   output ldf_pkg::cmd_type    head,
   output ldf_pkg::q_stat_type q_stat
);
   import ldf_pkg::*;

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign head         = q_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/core/ldf_back.sv -----
// back end: per-channel state, command execution, tick sweep, result register
module ldf_back (
   input  logic             clock,
   input  logic             reset,
   input  ldf_pkg::cfg_type cfg,
   input  ldf_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   output ldf_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_stall
);
   import ldf_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_SWEEP = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   chan_state_type    chan_ff [CHANNELS];
   logic [CHAN_W-1:0] idx_ff, idx_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              out_free;
   logic [CHAN_W-1:0] addr;
   chan_state_type    cur;
   chan_state_type    nxt;
   logic              wr;
   logic              emit;
   rsp_type           res;
   logic [31:0]       new_len;
   logic [15:0]       cnt1;
   logic [7:0]        idle_new;
   logic              mid;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign addr     = (state_ff == ST_SWEEP) ? idx_ff : cmd.chan;
   assign cur      = chan_ff[addr];
   assign new_len  = {cur.len[23:0], cmd.data};
   assign cnt1     = cur.cnt + 16'd1;
   assign idle_new = (cur.idle == IDLE_SAT) ? cur.idle : cur.idle + 8'd1;
   assign mid      = !cur.hdr || (cur.hcnt != '0);

   // command execution and tick sweep
   always_comb begin
      state_in            = state_ff;
      idx_in              = idx_ff;
      nres_in             = nres_ff;
      nxt                 = cur;
      wr                  = 1'b0;
      emit                = 1'b0;
      cmd_pop             = 1'b0;
      res.out_channel     = 4'(addr);
      res.payload         = '0;
      res.last            = 1'b1;
      res.event_res       = EV_BYTE;
      case (state_ff)
         ST_RUN: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_TICK: begin
                     state_in = ST_SWEEP;
                     idx_in   = '0;
                     nres_in  = '0;
                  end
                  OP_OPEN: begin
                     nxt      = CHAN_RESET;
                     nxt.open = 1'b1;
                     wr       = 1'b1;
                  end
                  OP_PEER: begin
                     if (cur.open) begin
                        nxt           = CHAN_RESET;
                        wr            = 1'b1;
                        emit          = 1'b1;
                        res.event_res = EV_PEER;
                     end
                  end
                  OP_DATA: begin
                     if (cur.open) begin
                        wr       = 1'b1;
                        nxt.idle = '0;
                        if (cur.hdr) begin
                           // collect the big-endian length
                           nxt.len  = new_len;
                           nxt.hcnt = cur.hcnt + 1'b1;
                           if (cur.hcnt == HDR_LAST) begin
                              nxt.hcnt = '0;
                              nxt.cnt  = '0;
                              if (new_len > {16'b0, cfg.max_length}) begin
                                 nxt           = CHAN_RESET;
                                 emit          = 1'b1;
                                 res.event_res = EV_TOOLONG;
                              end else if (new_len == '0) begin
                                 emit          = 1'b1;
                                 res.event_res = EV_EMPTY;
                              end else begin
                                 nxt.hdr = 1'b0;
                              end
                           end
                        end else begin
                           // payload byte pass-through
                           emit          = 1'b1;
                           res.payload   = cmd.data;
                           res.event_res = EV_BYTE;
                           if ({16'b0, cnt1} >= cur.len) begin
                              res.last = 1'b1;
                              nxt.hdr  = 1'b1;
                              nxt.hcnt = '0;
                              nxt.len  = '0;
                              nxt.cnt  = '0;
                           end else begin
                              res.last = 1'b0;
                              nxt.cnt  = cnt1;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            if (out_free) begin
               if (cur.open) begin
                  wr       = 1'b1;
                  nxt.idle = idle_new;
                  if (mid && (idle_new > cfg.idle_limit) &&
                      (nres_ff < NRES_W'(MAX_RESULTS))) begin
                     nxt           = CHAN_RESET;
                     emit          = 1'b1;
                     res.event_res = EV_IDLE;
                     nres_in       = nres_ff + 1'b1;
                  end
               end
               if (idx_ff == CHAN_W'(CHANNELS - 1)) begin
                  state_in = ST_RUN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // result register
   always_comb begin
      rsp_in = emit ? res : rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i] <= CHAN_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr) begin
            chan_ff[addr] <= nxt;
         end
      end
   end

   // sweep position and result payload
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      nres_ff <= nres_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/length_prefix_deframer_top.sv -----
// Length prefix deframer, top level. Each of 16 channels, once opened,
// collects a 4-byte big-endian length and then passes that many payload
// bytes through, flagging the final one; zero lengths, over-long lengths,
// peer closes and idle timeouts are reported as single-transaction events.
// A data, open or peer-close transaction is executed by the back end as
// it leaves the queue, so bytes flow at one per cycle while results are
// taken and no tick sweep runs. A tick is taken from the queue, then the
// back end walks the per-channel state one channel a cycle while results
// are taken, and the front keeps queuing behind it. A stalled result
// holds the back end; a two-entry command queue holds the front.
module length_prefix_deframer_top (
   input  logic             clock,
   input  logic             reset,
   input  ldf_pkg::req_type req_data,
   input  logic             req_valid,
   output logic             req_stall,
   output ldf_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import ldf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   q_stat_type q_stat;
   logic       push;
   cmd_type    push_cmd;
   cmd_type    head;
   logic       pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_LENGTH: cfg_in.max_length = csr_wdata;
            CSR_IDLE_LIMIT: cfg_in.idle_limit = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length <= MAX_LENGTH_RESET;
         cfg_ff.idle_limit <= IDLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ldf_front u_front (
      .req_data (req_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   ldf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .q_stat  (q_stat)
   );

   ldf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (head),
      .cmd_valid(!q_stat.empty),
      .cmd_pop  (pop),
      .rsp_data (rsp_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall)
   );

endmodule

// ----- rtl/core/ldf_checker.sv -----
// port-level checks of the length prefix deframer and their binding
module ldf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input ldf_pkg::rsp_type rsp_data,
   input logic             rsp_valid,
   input logic             rsp_stall
);
   import ldf_pkg::*;

   // reset empties the result register and the queue
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // message-level events close a message and carry no byte
   a_event_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.event_res != EV_BYTE)) |->
         (rsp_data.last && (rsp_data.payload == '0)))
      else $error("event result malformed");

   // only defined event codes leave the block
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.event_res <= EV_PEER))
      else $error("undefined event code");

endmodule

bind length_prefix_deframer_top ldf_checker u_ldf_checker (.*);
